/* sv/assert_macros.svh */
// Assertion macros included by the block's top-level RTL file.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* sv/bfs_pkg.sv */
// Package for the biased factor SGD step: sizes, fixed-point constants,
// request and result types, register indexes and the saturation function.
// Depends on nothing.
package bfs_pkg;

    localparam int NUM_USERS = 1024;
    localparam int NUM_ITEMS = 2048;
    localparam int RANK      = 16;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 24;
    localparam int RATE_W     = 24;
    localparam int VALUE_W    = 31;
    localparam int USER_W     = 10;
    localparam int ITEM_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam int PR_W  = 2 * DATA_W - FRAC_W;
    localparam int ACC_W = PR_W + $clog2(RANK) + 2;
    localparam int SUM_W = ACC_W + 1;

    localparam int UF_DEPTH = NUM_USERS * RANK;
    localparam int IF_DEPTH = NUM_ITEMS * RANK;
    localparam int UB_AW    = $clog2(NUM_USERS);
    localparam int IB_AW    = $clog2(NUM_ITEMS);
    localparam int UF_AW    = $clog2(UF_DEPTH);
    localparam int IF_AW    = $clog2(IF_DEPTH);
    localparam int K_W      = (RANK > 1) ? $clog2(RANK) : 1;
    localparam int CLR_LEN  = (IF_DEPTH > UF_DEPTH) ? IF_DEPTH : UF_DEPTH;
    localparam int CLR_W    = $clog2(CLR_LEN);

    localparam logic signed [DATA_W-1:0] INIT_WEIGHT = 32'sd1677722;
    localparam logic signed [DATA_W-1:0] DATA_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DATA_MIN    = 32'sh8000_0000;
    localparam logic signed [2*DATA_W-1:0] ROUND_HALF =
        (2*DATA_W)'(64'sd1 <<< (FRAC_W - 1));

    localparam logic [VALUE_W-1:0] GA_RESET = '0;
    localparam logic [RATE_W-1:0]  BR_RESET = 24'd16777;
    localparam logic [RATE_W-1:0]  FR_RESET = 24'd16777;
    localparam logic [RATE_W-1:0]  BD_RESET = 24'd167772;
    localparam logic [RATE_W-1:0]  FD_RESET = 24'd671089;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLOBAL_AVERAGE = 3'd0,
        CFG_BIAS_RATE      = 3'd1,
        CFG_FACTOR_RATE    = 3'd2,
        CFG_BIAS_DECAY     = 3'd3,
        CFG_FACTOR_DECAY   = 3'd4
    } bfs_cfg_t;

    typedef enum logic {
        FUNC_TRAIN   = 1'b0,
        FUNC_PREDICT = 1'b1
    } bfs_func_t;

    typedef struct packed {
        bfs_func_t           func;
        logic [USER_W-1:0]   user_index;
        logic [ITEM_W-1:0]   item_index;
        logic [VALUE_W-1:0]  rating;
    } bfs_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] prediction;
        logic signed [DATA_W-1:0] residual;
    } bfs_out_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } bfs_mul_op_t;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){x[SUM_W-1]}})
            r = x[DATA_W-1:0];
        else if (x[SUM_W-1])
            r = DATA_MIN;
        else
            r = DATA_MAX;
        return r;
    endfunction

endpackage

/* sv/bfs_ram.sv */
// Generic simple dual-port RAM: one write port and one registered read port.
// Depends on nothing.
module bfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bfs_mul.sv */
// Shared multiply unit: registered 32x32 signed product, rounded back to Q.24.
// Depends on bfs_pkg.
module bfs_mul
    import bfs_pkg::*;
(
    input  logic                     clk,
    input  bfs_mul_op_t              op,
    output logic signed [PR_W-1:0]   rnd
);

    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [2*DATA_W-1:0] prod_next;
    logic signed [2*DATA_W-1:0] biased;

    assign prod_next = op.a * op.b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Round half up, then an arithmetic shift by the fraction width.
    assign biased = prod_reg + ROUND_HALF;
    assign rnd    = biased[2*DATA_W-1:FRAC_W];

endmodule

/* sv/biased_factor_sgd_step.sv */
// Top level of the biased factor SGD step: sequencer, configuration,
// weight RAMs and output register. Depends on bfs_pkg, bfs_ram, bfs_mul.
//
//   channel  | flow          | payload   | handshake
//   sample   | into block    | bfs_in_t  | sample_valid / sample_stall
//   result   | out of block  | bfs_out_t | result_valid / result_stall
//   cfg      | into block    | index,data| cfg_valid / cfg_ready
//
// After reset the weight RAMs are set to 0.1 by a clearing pass over
// max(NUM_USERS, NUM_ITEMS) * RANK addresses (32768) before the first request.
// A predict request ends after the output step; a train request then runs
// the bias and factor passes on the one shared multiplier, which does
// one product per cycle: RANK for the dot product, four for the biases and
// six per factor pair, each pair after a RAM read step.
// A finished result waits in the output register; sample_stall is high whenever the block is not
// idle, and it holds in its output step only if a second result is ready before the first is taken.
`include "assert_macros.svh"

module biased_factor_sgd_step
    import bfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  bfs_in_t               sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output bfs_out_t              result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DOT   = 7'b0000100,
        S_SUM   = 7'b0001000,
        S_OUT   = 7'b0010000,
        S_BIAS  = 7'b0100000,
        S_FACT  = 7'b1000000
    } bfs_state_t;

    localparam int ST_W = 3;

    localparam logic [ST_W-1:0] BS_DECAY_U = 3'd0;
    localparam logic [ST_W-1:0] BS_DECAY_I = 3'd1;
    localparam logic [ST_W-1:0] BS_RATE_U  = 3'd2;
    localparam logic [ST_W-1:0] BS_WRITE_U = 3'd3;
    localparam logic [ST_W-1:0] BS_WRITE_I = 3'd4;

    localparam logic [ST_W-1:0] FS_READ    = 3'd0;
    localparam logic [ST_W-1:0] FS_ERR_B   = 3'd1;
    localparam logic [ST_W-1:0] FS_DECAY_A = 3'd2;
    localparam logic [ST_W-1:0] FS_ERR_A   = 3'd3;
    localparam logic [ST_W-1:0] FS_DECAY_B = 3'd4;
    localparam logic [ST_W-1:0] FS_RATE_U  = 3'd5;
    localparam logic [ST_W-1:0] FS_WRITE_U = 3'd6;
    localparam logic [ST_W-1:0] FS_WRITE_I = 3'd7;

    localparam logic [K_W-1:0]   K_LAST   = K_W'(RANK - 1);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_LEN - 1);

    bfs_state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [ST_W-1:0]  step_reg, step_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic issue_done_reg, issue_done_next;
    logic rv_reg, rv_next;
    logic pv_reg, pv_next;
    logic result_valid_reg, result_valid_next;

    logic [VALUE_W-1:0] ga_reg, ga_next;
    logic [RATE_W-1:0]  br_reg, br_next;
    logic [RATE_W-1:0]  fr_reg, fr_next;
    logic [RATE_W-1:0]  bd_reg, bd_next;
    logic [RATE_W-1:0]  fd_reg, fd_next;

    bfs_func_t          func_reg, func_next;
    logic               uok_reg, uok_next;
    logic               iok_reg, iok_next;
    logic [UB_AW-1:0]   ub_addr_reg, ub_addr_next;
    logic [IB_AW-1:0]   ib_addr_reg, ib_addr_next;
    logic [UF_AW-1:0]   uf_base_reg, uf_base_next;
    logic [IF_AW-1:0]   if_base_reg, if_base_next;
    logic [VALUE_W-1:0] rating_reg, rating_next;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [DATA_W-1:0] ub_reg, ub_next;
    logic signed [DATA_W-1:0] ib_reg, ib_next;
    logic signed [DATA_W-1:0] e_reg, e_next;
    logic signed [DATA_W-1:0] a_reg, a_next;
    logic signed [DATA_W-1:0] b_reg, b_next;
    logic signed [PR_W-1:0]   t_reg, t_next;
    logic signed [DATA_W-1:0] gu_reg, gu_next;
    logic signed [DATA_W-1:0] gi_reg, gi_next;
    bfs_out_t                 result_reg, result_next;

    logic [DATA_W-1:0] ub_rdata, ib_rdata, uf_rdata, if_rdata;
    logic signed [DATA_W-1:0] ub_m, ib_m, a_m, b_m;
    logic [UF_AW-1:0] uf_addr;
    logic [IF_AW-1:0] if_addr;

    logic              clearing;
    logic              ub_we, ib_we, uf_we, if_we;
    logic [UB_AW-1:0]  ub_waddr;
    logic [IB_AW-1:0]  ib_waddr;
    logic [UF_AW-1:0]  uf_waddr;
    logic [IF_AW-1:0]  if_waddr;
    logic [DATA_W-1:0] ub_wdata, ib_wdata, uf_wdata, if_wdata;

    bfs_mul_op_t              mul_op;
    logic signed [PR_W-1:0]   mul_rnd;
    logic signed [SUM_W-1:0]  grad_in;
    logic signed [DATA_W-1:0] grad;
    logic signed [DATA_W-1:0] w_sel;
    logic signed [DATA_W-1:0] new_w;
    logic signed [SUM_W-1:0]  err_full;
    logic                     accept;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign ub_m = uok_reg ? signed'(ub_rdata) : '0;
    assign ib_m = iok_reg ? signed'(ib_rdata) : '0;
    assign a_m  = uok_reg ? signed'(uf_rdata) : '0;
    assign b_m  = iok_reg ? signed'(if_rdata) : '0;

    assign uf_addr = uf_base_reg + UF_AW'(k_reg);
    assign if_addr = if_base_reg + IF_AW'(k_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_op.a = '0;
        mul_op.b = '0;
        unique case (state_reg)
            S_DOT:
            begin
                mul_op.a = a_m;
                mul_op.b = b_m;
            end
            S_BIAS:
            begin
                case (step_reg)
                    BS_DECAY_U:
                    begin
                        mul_op.a = signed'(DATA_W'(bd_reg));
                        mul_op.b = ub_reg;
                    end
                    BS_DECAY_I:
                    begin
                        mul_op.a = signed'(DATA_W'(bd_reg));
                        mul_op.b = ib_reg;
                    end
                    BS_RATE_U:
                    begin
                        mul_op.a = signed'(DATA_W'(br_reg));
                        mul_op.b = gu_reg;
                    end
                    BS_WRITE_U:
                    begin
                        mul_op.a = signed'(DATA_W'(br_reg));
                        mul_op.b = gi_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FACT:
            begin
                case (step_reg)
                    FS_ERR_B:
                    begin
                        mul_op.a = e_reg;
                        mul_op.b = b_m;
                    end
                    FS_DECAY_A:
                    begin
                        mul_op.a = signed'(DATA_W'(fd_reg));
                        mul_op.b = a_reg;
                    end
                    FS_ERR_A:
                    begin
                        mul_op.a = e_reg;
                        mul_op.b = a_reg;
                    end
                    FS_DECAY_B:
                    begin
                        mul_op.a = signed'(DATA_W'(fd_reg));
                        mul_op.b = b_reg;
                    end
                    FS_RATE_U:
                    begin
                        mul_op.a = signed'(DATA_W'(fr_reg));
                        mul_op.b = gu_reg;
                    end
                    FS_WRITE_U:
                    begin
                        mul_op.a = signed'(DATA_W'(fr_reg));
                        mul_op.b = gi_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    bfs_mul u_mul (
        .clk (clk),
        .op  (mul_op),
        .rnd (mul_rnd)
    );

    // Gradient and weight update share one saturating adder each.
    assign grad_in = (state_reg == S_BIAS) ? SUM_W'(e_reg) : SUM_W'(t_reg);
    assign grad    = sat_data(grad_in - SUM_W'(mul_rnd));

    always_comb
    begin
        if (state_reg == S_BIAS)
            w_sel = (step_reg == BS_WRITE_U) ? ub_reg : ib_reg;
        else
            w_sel = (step_reg == FS_WRITE_U) ? a_reg : b_reg;
    end

    assign new_w    = sat_data(SUM_W'(w_sel) + SUM_W'(mul_rnd));
    assign err_full = SUM_W'(signed'(DATA_W'(rating_reg))) - sum_reg;

    assign clearing = (state_reg == S_CLEAR);

    always_comb
    begin
        if (clearing)
        begin
            ub_we    = ({1'b0, clr_reg} < (CLR_W+1)'(NUM_USERS));
            ib_we    = ({1'b0, clr_reg} < (CLR_W+1)'(NUM_ITEMS));
            uf_we    = ({1'b0, clr_reg} < (CLR_W+1)'(UF_DEPTH));
            if_we    = ({1'b0, clr_reg} < (CLR_W+1)'(IF_DEPTH));
            ub_waddr = clr_reg[UB_AW-1:0];
            ib_waddr = clr_reg[IB_AW-1:0];
            uf_waddr = clr_reg[UF_AW-1:0];
            if_waddr = clr_reg[IF_AW-1:0];
            ub_wdata = INIT_WEIGHT;
            ib_wdata = INIT_WEIGHT;
            uf_wdata = INIT_WEIGHT;
            if_wdata = INIT_WEIGHT;
        end
        else
        begin
            ub_we    = (state_reg == S_BIAS) && (step_reg == BS_WRITE_U) && uok_reg;
            ib_we    = (state_reg == S_BIAS) && (step_reg == BS_WRITE_I) && iok_reg;
            uf_we    = (state_reg == S_FACT) && (step_reg == FS_WRITE_U) && uok_reg;
            if_we    = (state_reg == S_FACT) && (step_reg == FS_WRITE_I) && iok_reg;
            ub_waddr = ub_addr_reg;
            ib_waddr = ib_addr_reg;
            uf_waddr = uf_addr;
            if_waddr = if_addr;
            ub_wdata = new_w;
            ib_wdata = new_w;
            uf_wdata = new_w;
            if_wdata = new_w;
        end
    end

    bfs_ram #(.WIDTH(DATA_W), .DEPTH(NUM_USERS)) u_ub_ram (
        .clk   (clk),
        .we    (ub_we),
        .waddr (ub_waddr),
        .wdata (ub_wdata),
        .raddr (ub_addr_reg),
        .rdata (ub_rdata)
    );

    bfs_ram #(.WIDTH(DATA_W), .DEPTH(NUM_ITEMS)) u_ib_ram (
        .clk   (clk),
        .we    (ib_we),
        .waddr (ib_waddr),
        .wdata (ib_wdata),
        .raddr (ib_addr_reg),
        .rdata (ib_rdata)
    );

    bfs_ram #(.WIDTH(DATA_W), .DEPTH(UF_DEPTH)) u_uf_ram (
        .clk   (clk),
        .we    (uf_we),
        .waddr (uf_waddr),
        .wdata (uf_wdata),
        .raddr (uf_addr),
        .rdata (uf_rdata)
    );

    bfs_ram #(.WIDTH(DATA_W), .DEPTH(IF_DEPTH)) u_if_ram (
        .clk   (clk),
        .we    (if_we),
        .waddr (if_waddr),
        .wdata (if_wdata),
        .raddr (if_addr),
        .rdata (if_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        step_next         = step_reg;
        k_next            = k_reg;
        issue_done_next   = issue_done_reg;
        rv_next           = 1'b0;
        pv_next           = 1'b0;
        result_valid_next = result_valid_reg && result_stall;

        ga_next = ga_reg;
        br_next = br_reg;
        fr_next = fr_reg;
        bd_next = bd_reg;
        fd_next = fd_reg;

        func_next    = func_reg;
        uok_next     = uok_reg;
        iok_next     = iok_reg;
        ub_addr_next = ub_addr_reg;
        ib_addr_next = ib_addr_reg;
        uf_base_next = uf_base_reg;
        if_base_next = if_base_reg;
        rating_next  = rating_reg;

        acc_next    = acc_reg;
        sum_next    = sum_reg;
        ub_next     = ub_reg;
        ib_next     = ib_reg;
        e_next      = e_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        t_next      = t_reg;
        gu_next     = gu_reg;
        gi_next     = gi_reg;
        result_next = result_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GLOBAL_AVERAGE: ga_next = cfg_data[VALUE_W-1:0];
                CFG_BIAS_RATE:      br_next = cfg_data[RATE_W-1:0];
                CFG_FACTOR_RATE:    fr_next = cfg_data[RATE_W-1:0];
                CFG_BIAS_DECAY:     bd_next = cfg_data[RATE_W-1:0];
                CFG_FACTOR_DECAY:   fd_next = cfg_data[RATE_W-1:0];
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next       = sample.func;
                    uok_next        = (32'(sample.user_index) < 32'(NUM_USERS));
                    iok_next        = (32'(sample.item_index) < 32'(NUM_ITEMS));
                    ub_addr_next    = UB_AW'(sample.user_index);
                    ib_addr_next    = IB_AW'(sample.item_index);
                    uf_base_next    = (32'(sample.user_index) < 32'(NUM_USERS)) ?
                                      UF_AW'(sample.user_index) * UF_AW'(RANK) : '0;
                    if_base_next    = (32'(sample.item_index) < 32'(NUM_ITEMS)) ?
                                      IF_AW'(sample.item_index) * IF_AW'(RANK) : '0;
                    rating_next     = sample.rating;
                    acc_next        = '0;
                    k_next          = '0;
                    issue_done_next = 1'b0;
                    state_next      = S_DOT;
                end
            end
            S_DOT:
            begin
                if (!issue_done_reg)
                begin
                    if (k_reg == K_LAST)
                    begin
                        k_next          = '0;
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                rv_next = !issue_done_reg;
                pv_next = rv_reg;
                if (pv_reg)
                begin
                    acc_next = acc_reg + ACC_W'(mul_rnd);
                end
                if (issue_done_reg && !rv_reg && !pv_reg)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                sum_next   = SUM_W'(signed'(DATA_W'(ga_reg))) + SUM_W'(ub_m)
                             + SUM_W'(ib_m) + SUM_W'(acc_reg);
                ub_next    = ub_m;
                ib_next    = ib_m;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.prediction = sat_data(sum_reg);
                    result_next.residual   = sat_data(err_full);
                    result_valid_next      = 1'b1;
                    e_next                 = sat_data(err_full);
                    step_next              = '0;
                    state_next             = (func_reg == FUNC_PREDICT) ? S_IDLE : S_BIAS;
                end
            end
            S_BIAS:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    BS_DECAY_I: gu_next = grad;
                    BS_RATE_U:  gi_next = grad;
                    BS_WRITE_I:
                    begin
                        step_next  = '0;
                        k_next     = '0;
                        state_next = S_FACT;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FACT:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    FS_ERR_B:
                    begin
                        a_next = a_m;
                        b_next = b_m;
                    end
                    FS_DECAY_A: t_next  = mul_rnd;
                    FS_ERR_A:   gu_next = grad;
                    FS_DECAY_B: t_next  = mul_rnd;
                    FS_RATE_U:  gi_next = grad;
                    FS_WRITE_I:
                    begin
                        step_next = FS_READ;
                        if (k_reg == K_LAST)
                        begin
                            k_next     = '0;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            step_reg         <= '0;
            k_reg            <= '0;
            issue_done_reg   <= 1'b0;
            rv_reg           <= 1'b0;
            pv_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
            ga_reg           <= GA_RESET;
            br_reg           <= BR_RESET;
            fr_reg           <= FR_RESET;
            bd_reg           <= BD_RESET;
            fd_reg           <= FD_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            step_reg         <= step_next;
            k_reg            <= k_next;
            issue_done_reg   <= issue_done_next;
            rv_reg           <= rv_next;
            pv_reg           <= pv_next;
            result_valid_reg <= result_valid_next;
            ga_reg           <= ga_next;
            br_reg           <= br_next;
            fr_reg           <= fr_next;
            bd_reg           <= bd_next;
            fd_reg           <= fd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        uok_reg     <= uok_next;
        iok_reg     <= iok_next;
        ub_addr_reg <= ub_addr_next;
        ib_addr_reg <= ib_addr_next;
        uf_base_reg <= uf_base_next;
        if_base_reg <= if_base_next;
        rating_reg  <= rating_next;
        acc_reg     <= acc_next;
        sum_reg     <= sum_next;
        ub_reg      <= ub_next;
        ib_reg      <= ib_next;
        e_reg       <= e_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        t_reg       <= t_next;
        gu_reg      <= gu_next;
        gi_reg      <= gi_next;
        result_reg  <= result_next;
    end

    // Weight writes outside the clearing pass belong to train requests only.
    `ASSERT_IMPL(a_write_train_only, !clearing && (ub_we || ib_we || uf_we || if_we), func_reg == FUNC_TRAIN, "weight written for a predict request")
    `ASSERT_IMPL(a_result_from_out, $rose(result_valid_reg), $past(state_reg) == S_OUT, "result raised outside the output step")
    `ASSERT_IMPL(a_factor_start, state_reg == S_BIAS, k_reg == '0, "factor pass would not start at the first factor")
    `ASSERT_NEXT(a_accept_clears, accept, state_reg == S_DOT && acc_reg == '0 && !rv_reg, "dot product did not start clean")

endmodule

/* tb/biased_factor_sgd_step_tb.sv */
// Self-checking testbench for biased_factor_sgd_step: directed and random rating
// requests checked against a fixed-point predictor of the prediction and the SGD update.
// Depends on bfs_pkg and the biased_factor_sgd_step RTL.
module biased_factor_sgd_step_tb import bfs_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 12;
    localparam int TRAIN_CYCLES  = 9 * RANK + 11;
    localparam int SETTLE_CYCLES = 2 * TRAIN_CYCLES;
    localparam int IDLE_LIMIT    = 4 * CLR_LEN;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int RANDOM_PHASES = 6;
    localparam int MAX_REPORTS   = 40;

    localparam int ONE_Q24    = 1 << FRAC_W;
    localparam int RATING_TOP = 32'h7FFF_FFFF;
    // A row pair that was never trained, with a zero global average, predicts
    // two biases of 0.1 plus sixteen factor products of 0.01.
    localparam int FRESH_SUM  = 6039796;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_FACTOR_DECAY + 1);

    localparam int PRESET_FACTORY = 0;
    localparam int PRESET_EXTREME = 1;
    localparam int PRESET_ZERO    = 2;

    typedef struct packed {
        logic [VALUE_W-1:0] mean;
        logic [RATE_W-1:0]  bias_lr;
        logic [RATE_W-1:0]  factor_lr;
        logic [RATE_W-1:0]  bias_reg;
        logic [RATE_W-1:0]  factor_reg;
    } tuning_t;

    typedef struct {
        int        preset;
        bfs_func_t func;
        int        user;
        int        item;
        int        rating;
        bit        typed;
        int        want_prediction;
        int        want_residual;
    } plan_row_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    bfs_in_t               sample       = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    bfs_out_t              result;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    tuning_t presets [3] = '{
        '{GA_RESET, BR_RESET, FR_RESET, BD_RESET, FD_RESET},
        '{'1, '1, '1, '1, '1},
        '{'0, '0, '0, '0, '0}
    };

    plan_row_t directed_plan [18] = '{
        '{PRESET_FACTORY, FUNC_PREDICT, 0, 0, 0, 1'b1, FRESH_SUM, -FRESH_SUM},
        '{PRESET_FACTORY, FUNC_PREDICT, 1023, 2047, RATING_TOP, 1'b1,
          FRESH_SUM, RATING_TOP - FRESH_SUM},
        '{PRESET_FACTORY, FUNC_TRAIN, 0, 0, RATING_TOP, 1'b1,
          FRESH_SUM, RATING_TOP - FRESH_SUM},
        '{PRESET_FACTORY, FUNC_PREDICT, 0, 0, 5 * ONE_Q24, 1'b0, 0, 0},
        '{PRESET_FACTORY, FUNC_TRAIN, 1023, 2047, 0, 1'b1, FRESH_SUM, -FRESH_SUM},
        '{PRESET_FACTORY, FUNC_TRAIN, 0, 2047, 3 * ONE_Q24, 1'b0, 0, 0},
        '{PRESET_FACTORY, FUNC_TRAIN, 1023, 0, ONE_Q24, 1'b0, 0, 0},
        '{PRESET_FACTORY, FUNC_PREDICT, 682, 1365, 5 * ONE_Q24 / 2, 1'b0, 0, 0},
        '{PRESET_EXTREME, FUNC_PREDICT, 5, 5, 0, 1'b1, int'(DATA_MAX), int'(DATA_MIN)},
        '{PRESET_EXTREME, FUNC_TRAIN, 5, 5, 0, 1'b1, int'(DATA_MAX), int'(DATA_MIN)},
        '{PRESET_EXTREME, FUNC_TRAIN, 5, 5, RATING_TOP, 1'b0, 0, 0},
        '{PRESET_EXTREME, FUNC_TRAIN, 5, 5, 0, 1'b0, 0, 0},
        '{PRESET_EXTREME, FUNC_TRAIN, 5, 6, RATING_TOP, 1'b0, 0, 0},
        '{PRESET_EXTREME, FUNC_PREDICT, 5, 5, RATING_TOP, 1'b0, 0, 0},
        '{PRESET_ZERO, FUNC_TRAIN, 6, 7, 0, 1'b1, FRESH_SUM, -FRESH_SUM},
        '{PRESET_ZERO, FUNC_TRAIN, 6, 7, 0, 1'b1, FRESH_SUM, -FRESH_SUM},
        '{PRESET_ZERO, FUNC_PREDICT, 5, 5, ONE_Q24, 1'b0, 0, 0},
        '{PRESET_ZERO, FUNC_TRAIN, 341, 1706, RATING_TOP, 1'b0, 0, 0}
    };

    logic [VALUE_W-1:0] mean_rating;
    logic [RATE_W-1:0]  bias_lr;
    logic [RATE_W-1:0]  factor_lr;
    logic [RATE_W-1:0]  bias_reg;
    logic [RATE_W-1:0]  factor_reg;

    int user_bias_w   [NUM_USERS];
    int item_bias_w   [NUM_ITEMS];
    int user_factor_w [UF_DEPTH];
    int item_factor_w [IF_DEPTH];

    bfs_out_t pending_ratings [$];

    int burst_left    = 0;
    int stall_window  = 0;
    int stall_mode    = 0;
    int idle_cycles   = 0;
    int mismatches    = 0;
    int reports_left  = MAX_REPORTS;
    int results_seen  = 0;
    int train_count   = 0;
    int predict_count = 0;
    int setting_count = 0;

    biased_factor_sgd_step DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic longint round_q24(longint x);
        return (x + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function automatic int clamp_word(longint x);
        if (x > longint'(DATA_MAX))
            return int'(DATA_MAX);
        if (x < longint'(DATA_MIN))
            return int'(DATA_MIN);
        return int'(x);
    endfunction

    function automatic int nudge_weight(int w, longint signal, logic [RATE_W-1:0] rate,
                                        logic [RATE_W-1:0] decay);
        int g;
        g = clamp_word(signal - round_q24(longint'(decay) * w));
        return clamp_word(longint'(w) + round_q24(longint'(rate) * g));
    endfunction

    function automatic void reset_model();
        mean_rating = GA_RESET;
        bias_lr     = BR_RESET;
        factor_lr   = FR_RESET;
        bias_reg    = BD_RESET;
        factor_reg  = FD_RESET;
        foreach (user_bias_w[i])
            user_bias_w[i] = INIT_WEIGHT;
        foreach (item_bias_w[i])
            item_bias_w[i] = INIT_WEIGHT;
        foreach (user_factor_w[i])
            user_factor_w[i] = INIT_WEIGHT;
        foreach (item_factor_w[i])
            item_factor_w[i] = INIT_WEIGHT;
    endfunction

    function automatic void tune_model(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GLOBAL_AVERAGE: mean_rating = data[VALUE_W-1:0];
            CFG_BIAS_RATE:      bias_lr     = data[RATE_W-1:0];
            CFG_FACTOR_RATE:    factor_lr   = data[RATE_W-1:0];
            CFG_BIAS_DECAY:     bias_reg    = data[RATE_W-1:0];
            CFG_FACTOR_DECAY:   factor_reg  = data[RATE_W-1:0];
            default: ;
        endcase
    endfunction

    // Returns the prediction and residual of one request and, for a training
    // request, moves the biases and factors as the block should.
    function automatic bfs_out_t rate_sample(bfs_in_t req);
        int unsigned u;
        int unsigned it;
        bit          u_ok;
        bit          i_ok;
        int          ubase;
        int          ibase;
        int          ub;
        int          ib;
        int          a;
        int          b;
        int          e;
        longint      dot;
        longint      total;
        bfs_out_t    res;
        u     = req.user_index;
        it    = req.item_index;
        u_ok  = u < NUM_USERS;
        i_ok  = it < NUM_ITEMS;
        ubase = u_ok ? u * RANK : 0;
        ibase = i_ok ? it * RANK : 0;
        ub    = u_ok ? user_bias_w[u] : 0;
        ib    = i_ok ? item_bias_w[it] : 0;
        dot   = 0;
        for (int k = 0; k < RANK; k++)
        begin
            a = u_ok ? user_factor_w[ubase + k] : 0;
            b = i_ok ? item_factor_w[ibase + k] : 0;
            dot += round_q24(longint'(a) * b);
        end
        total = longint'(mean_rating) + ub + ib + dot;
        e     = clamp_word(longint'(req.rating) - total);
        if (req.func == FUNC_TRAIN)
        begin
            if (u_ok)
                user_bias_w[u] = nudge_weight(ub, e, bias_lr, bias_reg);
            if (i_ok)
                item_bias_w[it] = nudge_weight(ib, e, bias_lr, bias_reg);
            for (int k = 0; k < RANK; k++)
            begin
                a = u_ok ? user_factor_w[ubase + k] : 0;
                b = i_ok ? item_factor_w[ibase + k] : 0;
                if (u_ok)
                    user_factor_w[ubase + k] =
                        nudge_weight(a, round_q24(longint'(e) * b), factor_lr, factor_reg);
                if (i_ok)
                    item_factor_w[ibase + k] =
                        nudge_weight(b, round_q24(longint'(e) * a), factor_lr, factor_reg);
            end
        end
        res.prediction = clamp_word(total);
        res.residual   = e;
        return res;
    endfunction

    function automatic logic [RATE_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return RATE_W'($urandom());
            default: return RATE_W'($urandom_range(0, ONE_Q24 / 16));
        endcase
    endfunction

    function automatic tuning_t random_tuning();
        tuning_t t;
        if ($urandom_range(0, 4) == 0)
            t.mean = VALUE_W'($urandom());
        else
            t.mean = VALUE_W'($urandom_range(0, 5 * ONE_Q24));
        t.bias_lr    = pick_gain();
        t.factor_lr  = pick_gain();
        t.bias_reg   = pick_gain();
        t.factor_reg = pick_gain();
        return t;
    endfunction

    // Most requests hit a small set of rows so that training accumulates.
    function automatic bfs_in_t random_request();
        bfs_in_t r;
        r.func = ($urandom_range(0, 3) == 0) ? FUNC_PREDICT : FUNC_TRAIN;
        if ($urandom_range(0, 9) < 6)
        begin
            r.user_index = USER_W'($urandom_range(0, 7));
            r.item_index = ITEM_W'($urandom_range(0, 15));
        end
        else
        begin
            r.user_index = USER_W'($urandom());
            r.item_index = ITEM_W'($urandom());
        end
        case ($urandom_range(0, 19))
            0:       r.rating = '0;
            1:       r.rating = '1;
            2, 3, 4: r.rating = VALUE_W'($urandom());
            default: r.rating = VALUE_W'($urandom_range(ONE_Q24, 5 * ONE_Q24));
        endcase
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tune_model(idx, data);
    endtask

    task automatic apply_tuning(tuning_t t);
        write_reg(CFG_GLOBAL_AVERAGE, t.mean);
        write_reg(CFG_BIAS_RATE, {7'($urandom()), t.bias_lr});
        write_reg(CFG_FACTOR_RATE, {7'($urandom()), t.factor_lr});
        write_reg(CFG_BIAS_DECAY, {7'($urandom()), t.bias_reg});
        write_reg(CFG_FACTOR_DECAY, {7'($urandom()), t.factor_reg});
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_FIRST, {CFG_IDX_W{1'b1}})),
                  CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        while (pending_ratings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic send_request(bfs_in_t req, bit typed, int want_prediction,
                                int want_residual);
        bfs_out_t want;
        int       gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 30);
                default: gap = $urandom_range(31, 250);
            endcase
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        burst_left--;
        sample       <= req;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        want = rate_sample(req);
        if (typed)
        begin
            want.prediction = want_prediction;
            want.residual   = want_residual;
        end
        pending_ratings.push_back(want);
        if (req.func == FUNC_TRAIN)
            train_count++;
        else
            predict_count++;
    endtask

    task automatic flag_field(string field, int want_v, int got_v);
        mismatches++;
        if (reports_left > 0)
        begin
            reports_left--;
            $error("%s: expected %0d, actual %0d", field, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_window == 0)
        begin
            stall_mode   <= $urandom_range(0, 3);
            stall_window <= $urandom_range(20, 300);
        end
        else
        begin
            stall_window <= stall_window - 1;
        end
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= 1'($urandom_range(0, 1));
            2:       result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        bfs_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_ratings.size() == 0)
            begin
                mismatches++;
                $error("result: none expected, prediction %0d residual %0d",
                       result.prediction, result.residual);
            end
            else
            begin
                want = pending_ratings.pop_front();
                if (result.prediction !== want.prediction)
                    flag_field("prediction", want.prediction, result.prediction);
                if (result.residual !== want.residual)
                    flag_field("residual", want.residual, result.residual);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding.", pending_ratings.size());
            $display("biased_factor_sgd_step test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int      preset_now;
        bfs_in_t req;
        reset_model();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        preset_now = PRESET_FACTORY;
        foreach (directed_plan[row])
        begin
            if (directed_plan[row].preset != preset_now)
            begin
                settle();
                preset_now = directed_plan[row].preset;
                apply_tuning(presets[preset_now]);
            end
            req.func       = directed_plan[row].func;
            req.user_index = USER_W'(directed_plan[row].user);
            req.item_index = ITEM_W'(directed_plan[row].item);
            req.rating     = VALUE_W'(directed_plan[row].rating);
            send_request(req, directed_plan[row].typed, directed_plan[row].want_prediction,
                         directed_plan[row].want_residual);
        end
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            apply_tuning(random_tuning());
            for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
                send_request(random_request(), 1'b0, 0, 0);
        end
        settle();
        $display("Ran %0d train and %0d predict requests under %0d register settings.",
                 train_count, predict_count, setting_count + 1);
        $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("biased_factor_sgd_step test passed");
        else
            $display("biased_factor_sgd_step test failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/bfs_pkg.sv
sv/bfs_ram.sv
sv/bfs_mul.sv
sv/biased_factor_sgd_step.sv
tb/biased_factor_sgd_step_tb.sv
